FILE: src/modal_resonator_bank_macros.svh
// Assertion macros for the modal resonator bank checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef MODAL_RESONATOR_BANK_MACROS_SVH
`define MODAL_RESONATOR_BANK_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MRB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MRB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mrb_pkg.sv
// Shared types, constants and the sine table builder for the modal resonator bank.
// No dependencies; used by every module of the block.
`default_nettype none

package mrb_pkg;

    // Bank size and number formats.
    localparam int MODES        = 8;
    localparam int PHASE_BITS   = 24;
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
    localparam int SINE_W       = 16;
    localparam int START_W      = 17;
    localparam int DECAY_W      = 24;
    localparam int TIME_W       = 16;
    localparam int AMP_W        = 32;
    localparam int SAMPLE_W     = 20;
    localparam int CNT_W        = (MODES > 1) ? $clog2(MODES) : 1;
    localparam int LEFT_W       = TIME_W + 3;
    localparam int PROD_W       = AMP_W + 1 + SINE_W;
    localparam int ACC_W        = PROD_W + $clog2(MODES);
    localparam int SAMPLE_MAX   = 524287;
    localparam int SAMPLE_MIN   = -524288;

    // Command codes.
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_STRIKE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // Sine series constants: 2*pi in Q28 and the factorial step divisors.
    localparam logic [63:0] TWO_PI_Q28 = 64'd1686629713;
    localparam logic [63:0] SERIES_DIV [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    // Settings of one mode slot, written by a load request.
    typedef struct packed {
        logic [PHASE_BITS-1:0] step;
        logic [START_W-1:0]    start;
        logic [DECAY_W-1:0]    decay;
        logic [TIME_W-1:0]     dtime;
        logic                  en;
        logic                  audible;
    } mode_cfg_t;

    // Full record held by one cell: settings plus running oscillator state.
    typedef struct packed {
        mode_cfg_t             cfg;
        logic [PHASE_BITS-1:0] phase;
        logic [AMP_W-1:0]      amp;
    } mode_rec_t;

    // Framing of the term stream into the voice unit.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } voice_ctl_t;

    typedef logic signed [SINE_W-1:0] sine_rom_t [SINE_ENTRIES];

    // Builds the Q1.15 sine table by a truncating Taylor series in Q30.
    function automatic sine_rom_t build_sine();
        sine_rom_t   tab;
        logic [63:0] t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] v;
        logic        neg;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            t   = 64'(k) << (32 - SINE_BITS);
            neg = 1'b0;
            if (t >= (64'd1 << 31)) begin
                neg = 1'b1;
                t   = t - (64'd1 << 31);
            end
            if (t > (64'd1 << 30)) begin
                t = (64'd1 << 31) - t;
            end
            x    = (t * TWO_PI_Q28) >> 30;
            x2   = (x * x) >> 30;
            term = x;
            acc  = x;
            for (int n = 1; n <= 8; n++) begin
                term = ((term * x2) >> 30) / SERIES_DIV[n-1];
                if ((n & 1) != 0) begin
                    acc = acc - term;
                end
                else begin
                    acc = acc + term;
                end
            end
            v = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            tab[k] = neg ? -$signed(v[SINE_W-1:0]) : $signed(v[SINE_W-1:0]);
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

FILE: src/mrb_cell.sv
// One cell of the mode ring: holds the settings and oscillator state of one mode.
// Depends on mrb_pkg for the record types.
`default_nettype none

module mrb_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              shift_en,
    input  wire mrb_pkg::mode_rec_t shift_in,
    input  wire logic              load_en,
    input  wire mrb_pkg::mode_cfg_t load_cfg,
    output mrb_pkg::mode_rec_t     rec
);

    mrb_pkg::mode_rec_t rec_reg;
    mrb_pkg::mode_rec_t rec_next;

    // The ring shift has priority; loads only arrive while the ring is parked.
    always_comb
    begin
        rec_next = rec_reg;
        if (shift_en)
        begin
            rec_next = shift_in;
        end
        else if (load_en)
        begin
            rec_next.cfg = load_cfg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec = rec_reg;

endmodule

`default_nettype wire

FILE: src/mrb_update.sv
// Oscillator update between the tail and the head of the mode ring.
// Depends on mrb_pkg for the record type and widths.
`default_nettype none

module mrb_update (
    input  wire logic              strike,
    input  wire mrb_pkg::mode_rec_t rec_in,
    output mrb_pkg::mode_rec_t     rec_out
);

    localparam int DP_W = mrb_pkg::AMP_W + mrb_pkg::DECAY_W;

    logic [DP_W-1:0] decay_prod;

    assign decay_prod = DP_W'(rec_in.amp) * DP_W'(rec_in.cfg.decay);

    // A strike restarts every mode; a tick decays and advances enabled modes only.
    always_comb
    begin
        rec_out = rec_in;
        if (strike)
        begin
            rec_out.phase = '0;
            rec_out.amp   = {rec_in.cfg.start, (mrb_pkg::AMP_W - mrb_pkg::START_W)'(0)};
        end
        else if (rec_in.cfg.en)
        begin
            rec_out.amp   = decay_prod[DP_W-1:mrb_pkg::DECAY_W];
            rec_out.phase = rec_in.phase + rec_in.cfg.step;
        end
    end

endmodule

`default_nettype wire

FILE: src/mrb_voice.sv
// Term pipeline: sine lookup, amplitude product, accumulation and output rounding.
// Depends on mrb_pkg for the sine table builder, framing struct and widths.
`default_nettype none

module mrb_voice (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire mrb_pkg::voice_ctl_t               ctl,
    input  wire logic                              gate,
    input  wire logic [mrb_pkg::PHASE_BITS-1:0]    phase,
    input  wire logic [mrb_pkg::AMP_W-1:0]         amp,
    output logic                                   done,
    output logic signed [mrb_pkg::SAMPLE_W-1:0]    sample
);

    localparam int ACC_W = mrb_pkg::ACC_W;
    localparam int Q_W   = ACC_W - 30;
    localparam mrb_pkg::sine_rom_t SINE_ROM = mrb_pkg::build_sine();

    mrb_pkg::voice_ctl_t                   ctl1_reg;
    mrb_pkg::voice_ctl_t                   ctl2_reg;
    logic                                  gate1_reg;
    logic [mrb_pkg::AMP_W-1:0]             amp1_reg;
    logic signed [mrb_pkg::SINE_W-1:0]     sine1_reg;
    logic signed [mrb_pkg::PROD_W-1:0]     prod2_reg;
    logic signed [ACC_W-1:0]               acc_reg;
    logic                                  done_reg;
    logic [mrb_pkg::SINE_BITS-1:0]         sine_idx;
    logic signed [ACC_W:0]                 biased;
    logic signed [Q_W-1:0]                 quot;

    assign sine_idx = phase[mrb_pkg::PHASE_BITS-1 -: mrb_pkg::SINE_BITS];

    // Framing flags travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl1_reg <= ctl;
            ctl2_reg <= ctl1_reg;
            done_reg <= ctl2_reg.valid && ctl2_reg.last;
        end
    end

    // Stage one: table read; stage two: product; stage three: running sum.
    always_ff @(posedge clk)
    begin
        sine1_reg <= SINE_ROM[sine_idx];
        amp1_reg  <= amp;
        gate1_reg <= gate;
        if (gate1_reg)
        begin
            prod2_reg <= $signed({1'b0, amp1_reg}) * sine1_reg;
        end
        else
        begin
            prod2_reg <= '0;
        end
        if (ctl2_reg.valid)
        begin
            if (ctl2_reg.first)
            begin
                acc_reg <= ACC_W'(prod2_reg);
            end
            else
            begin
                acc_reg <= acc_reg + ACC_W'(prod2_reg);
            end
        end
    end

    // Round half up to Q5.15 by an arithmetic shift, then saturate.
    always_comb
    begin
        biased = (ACC_W+1)'(acc_reg) + $signed((ACC_W+1)'(64'd1 << 30));
        quot   = biased[ACC_W:31];
        if (quot > $signed(Q_W'(mrb_pkg::SAMPLE_MAX)))
        begin
            sample = $signed(mrb_pkg::SAMPLE_W'(mrb_pkg::SAMPLE_MAX));
        end
        else if (quot < $signed(Q_W'(mrb_pkg::SAMPLE_MIN)))
        begin
            sample = $signed(mrb_pkg::SAMPLE_W'(mrb_pkg::SAMPLE_MIN));
        end
        else
        begin
            sample = quot[mrb_pkg::SAMPLE_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

FILE: src/modal_resonator_bank.sv
// Top level of the modal resonator bank: request decode, mode ring and output register.
// Depends on mrb_pkg, mrb_cell, mrb_update and mrb_voice.
//
//   channel   handshake               payload
//   input     in_valid / in_stall     command, mode_index, phase_step, start_amplitude,
//                                     decay_factor, decay_time, mode_enable
//   output    out_valid / out_stall   sample, last_sample
//
// A load completes on acceptance. A strike keeps the block busy for one turn of the mode ring.
// A tick inside a run takes one turn of the ring through the shared sine table and
// multiplier, then drains the term pipeline and registers the result.
// A tick outside a run, and command three, leave the block idle and give no result.
// Reset clears every mode enable, phase and amplitude and ends any run.
// A stalled result holds in the output register; a further tick's result waits for it to leave.
`default_nettype none

module modal_resonator_bank (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [1:0]                         command,
    input  wire logic [2:0]                         mode_index,
    input  wire logic [23:0]                        phase_step,
    input  wire logic [mrb_pkg::START_W-1:0]        start_amplitude,
    input  wire logic [mrb_pkg::DECAY_W-1:0]        decay_factor,
    input  wire logic [mrb_pkg::TIME_W-1:0]         decay_time,
    input  wire logic                               mode_enable,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [mrb_pkg::SAMPLE_W-1:0]     sample,
    output logic                                    last_sample
);

    localparam int MODES  = mrb_pkg::MODES;
    localparam int CNT_W  = mrb_pkg::CNT_W;
    localparam int LEFT_W = mrb_pkg::LEFT_W;
    localparam int LIM_W  = mrb_pkg::PHASE_BITS + 7;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_STRIKE = 3'd1;
    localparam logic [2:0] ST_TICK   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    localparam logic [LIM_W-1:0] AUDIBLE_LIMIT = LIM_W'(47) << mrb_pkg::PHASE_BITS;

    logic [2:0]                          state_reg;
    logic [2:0]                          state_next;
    logic [CNT_W-1:0]                    cnt_reg;
    logic [CNT_W-1:0]                    cnt_next;
    logic [mrb_pkg::TIME_W-1:0]          tmax_reg;
    logic [mrb_pkg::TIME_W-1:0]          tmax_next;
    logic [LEFT_W-1:0]                   left_reg;
    logic [LEFT_W-1:0]                   left_next;
    logic                                last_flag_reg;
    logic                                last_flag_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic signed [mrb_pkg::SAMPLE_W-1:0] sample_reg;
    logic                                last_out_reg;

    logic                                accept;
    logic                                rotate;
    logic                                cnt_last;
    logic                                emit_load;
    logic [mrb_pkg::TIME_W-1:0]          tmax_new;
    logic [LEFT_W-1:0]                   run_len;
    logic [LIM_W-1:0]                    step_x100;
    mrb_pkg::mode_cfg_t                  load_cfg;
    mrb_pkg::mode_rec_t                  cell_rec [MODES];
    mrb_pkg::mode_rec_t                  chain_in [MODES];
    mrb_pkg::mode_rec_t                  tail_rec;
    mrb_pkg::mode_rec_t                  head_rec;
    mrb_pkg::voice_ctl_t                 voice_ctl;
    logic                                voice_done;
    logic signed [mrb_pkg::SAMPLE_W-1:0] voice_sample;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign rotate   = (state_reg == ST_STRIKE) || (state_reg == ST_TICK);
    assign cnt_last = (cnt_reg == CNT_W'(MODES - 1));
    assign tail_rec = cell_rec[MODES-1];

    // Settings for a load request; the silence test is settled once here.
    assign step_x100 = LIM_W'(phase_step[mrb_pkg::PHASE_BITS-1:0]) * LIM_W'(100);

    always_comb
    begin
        load_cfg.step    = phase_step[mrb_pkg::PHASE_BITS-1:0];
        load_cfg.start   = start_amplitude;
        load_cfg.decay   = decay_factor;
        load_cfg.dtime   = decay_time;
        load_cfg.en      = mode_enable;
        load_cfg.audible = (step_x100 < AUDIBLE_LIMIT);
    end

    // Ring of mode cells; the update unit closes the ring from tail to head.
    for (genvar g = 0; g < MODES; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            assign chain_in[g] = head_rec;
        end
        else
        begin : g_link
            assign chain_in[g] = cell_rec[g-1];
        end

        mrb_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (rotate),
            .shift_in (chain_in[g]),
            .load_en  (accept && (command == mrb_pkg::CMD_LOAD) && (int'(mode_index) == g)),
            .load_cfg (load_cfg),
            .rec      (cell_rec[g])
        );
    end

    mrb_update u_update (
        .strike  (state_reg == ST_STRIKE),
        .rec_in  (tail_rec),
        .rec_out (head_rec)
    );

    // Each mode passes the tail once per tick; the voice sums its term.
    always_comb
    begin
        voice_ctl.valid = (state_reg == ST_TICK);
        voice_ctl.first = (cnt_reg == '0);
        voice_ctl.last  = cnt_last;
    end

    mrb_voice u_voice (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (voice_ctl),
        .gate   (tail_rec.cfg.en && tail_rec.cfg.audible),
        .phase  (tail_rec.phase),
        .amp    (tail_rec.amp),
        .done   (voice_done),
        .sample (voice_sample)
    );

    // Longest enabled decay time seen so far in a strike turn, and the run it gives.
    always_comb
    begin
        tmax_new = tmax_reg;
        if (tail_rec.cfg.en && (tail_rec.cfg.dtime > tmax_reg))
        begin
            tmax_new = tail_rec.cfg.dtime;
        end
        run_len = (LEFT_W'(tmax_new) << 3) - LEFT_W'(tmax_new) + LEFT_W'(1);
    end

    assign emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    // Request sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        tmax_next      = tmax_reg;
        left_next      = left_reg;
        last_flag_next = last_flag_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    if (command == mrb_pkg::CMD_STRIKE)
                    begin
                        state_next = ST_STRIKE;
                        tmax_next  = '0;
                    end
                    else if ((command == mrb_pkg::CMD_TICK) && (left_reg != '0))
                    begin
                        state_next     = ST_TICK;
                        last_flag_next = (left_reg == LEFT_W'(1));
                        left_next      = left_reg - LEFT_W'(1);
                    end
                end
            end
            ST_STRIKE:
            begin
                tmax_next = tmax_new;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_last)
                begin
                    left_next  = run_len;
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (voice_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: cleared when taken, loaded when a result is ready.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (emit_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            tmax_reg      <= '0;
            left_reg      <= '0;
            last_flag_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            tmax_reg      <= tmax_next;
            left_reg      <= left_next;
            last_flag_reg <= last_flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            sample_reg   <= voice_sample;
            last_out_reg <= last_flag_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample      = sample_reg;
    assign last_sample = last_out_reg;

endmodule

`default_nettype wire

FILE: src/mrb_checker.sv
// Port-level checks for the modal resonator bank, bound to the top level.
// Depends on mrb_pkg and modal_resonator_bank_macros.svh.
`default_nettype none

`include "modal_resonator_bank_macros.svh"

module mrb_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_stall,
    input wire logic [1:0]                         command,
    input wire logic                               out_valid,
    input wire logic                               out_stall,
    input wire logic signed [mrb_pkg::SAMPLE_W-1:0] sample,
    input wire logic                               last_sample
);

    // A stalled result stays put.
    `MRB_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample) && $stable(last_sample), "stalled result changed")

    // An accepted strike request makes the block busy.
    `MRB_ASSERT_NXT(a_strike_busy, in_valid && !in_stall && (command == mrb_pkg::CMD_STRIKE), in_stall, "strike request did not occupy the block")

    // A load request completes at once.
    `MRB_ASSERT_NXT(a_load_quick, in_valid && !in_stall && (command == mrb_pkg::CMD_LOAD), !in_stall, "load request stalled the input")

    // A new result only appears right after the block was busy with a request.
    `MRB_ASSERT_IMP(a_result_source, $rose(out_valid), $past(in_stall), "result appeared without a request in progress")

endmodule

bind modal_resonator_bank mrb_checker u_mrb_checker (.*);

`default_nettype wire
